FILE: design/sted_pkg.sv
// ----------------------------------------------------------------------------
// sted_pkg
// Shared constants and types for the single-tap echo delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sted_pkg;

    // Delay memory depth, in samples
    localparam int DELAY_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    // Field widths
    localparam int SAMP_W = 16;
    localparam int DLY_W  = 16;
    // Clamped delay must be able to hold DELAY_DEPTH itself
    localparam int DEFF_W = 17;

    // 3*|x| fits in 18 bits for any 16-bit magnitude up to 32768
    localparam int TRIPLE_W = SAMP_W + 2;

    // floor(n/5) = (n * 52429) >> 18, exact for every n below 2^18
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int          DIV5_SHIFT = 18;
    localparam int          PROD_W     = TRIPLE_W + 16;

    // Per-sample tag carried from the control unit into the datapath
    typedef struct packed {
        logic echo;   // echo term is active for this sample
        logic zero;   // zero delay: the delayed sample is the input itself
    } t_tag;

endpackage

`default_nettype wire

FILE: design/sted_delay_ram.sv
// ----------------------------------------------------------------------------
// sted_delay_ram
// Sample delay memory: one write port and one registered read port.
// A read and a write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sted_delay_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [sted_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire logic [sted_pkg::SAMP_W-1:0]   i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [sted_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic      [sted_pkg::SAMP_W-1:0]   o_rd_data
);

    logic [sted_pkg::SAMP_W-1:0] r_mem [sted_pkg::DELAY_DEPTH];
    logic [sted_pkg::SAMP_W-1:0] r_rd_data;

    // Write the new sample, read the delayed one (read-first)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/sted_ctrl.sv
// ----------------------------------------------------------------------------
// sted_ctrl
// Write pointer, clip sample counter and delay-tap address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module sted_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_clip_start,
    input  wire logic [sted_pkg::DLY_W-1:0]    i_delay,
    output logic      [sted_pkg::ADDR_W-1:0]   o_wr_addr,
    output logic      [sted_pkg::ADDR_W-1:0]   o_rd_addr,
    output sted_pkg::t_tag                     o_tag
);

    localparam int SUM_W = sted_pkg::DEFF_W + 1;

    logic [sted_pkg::ADDR_W-1:0] r_wp, n_wp;
    logic [sted_pkg::DLY_W-1:0]  r_seen, n_seen;
    logic [sted_pkg::DLY_W-1:0]  seen_cur;
    logic [sted_pkg::DEFF_W-1:0] d_eff;
    logic [SUM_W-1:0]            wp_x;
    logic [SUM_W-1:0]            d_x;
    logic [SUM_W-1:0]            tap;

    // Clamp the delay to the memory depth
    always_comb begin
        if (sted_pkg::DEFF_W'(i_delay) > sted_pkg::DEFF_W'(sted_pkg::DELAY_DEPTH)) begin
            d_eff = sted_pkg::DEFF_W'(sted_pkg::DELAY_DEPTH);
        end else begin
            d_eff = sted_pkg::DEFF_W'(i_delay);
        end
    end

    // Tap address: write pointer minus delay, modulo the depth
    always_comb begin
        wp_x = SUM_W'(r_wp);
        d_x  = SUM_W'(d_eff);
        if (wp_x >= d_x) begin
            tap = wp_x - d_x;
        end else begin
            tap = wp_x + SUM_W'(sted_pkg::DELAY_DEPTH) - d_x;
        end
    end

    // Restart the count on a clip start, then decide whether the echo applies
    always_comb begin
        seen_cur   = i_clip_start ? '0 : r_seen;
        o_tag.echo = sted_pkg::DEFF_W'(seen_cur) >= d_eff;
        o_tag.zero = (d_eff == '0);
        n_seen     = (seen_cur == '1) ? seen_cur : seen_cur + 1'b1;
        n_wp       = (r_wp == sted_pkg::ADDR_W'(sted_pkg::DELAY_DEPTH - 1)) ? '0
                                                                          : r_wp + 1'b1;
    end

    // Advance pointer and counter on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_seen <= '0;
        end else if (i_accept) begin
            r_wp   <= n_wp;
            r_seen <= n_seen;
        end
    end

    assign o_wr_addr = r_wp;
    assign o_rd_addr = tap[sted_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

FILE: design/sted_echo_path.sv
// ----------------------------------------------------------------------------
// sted_echo_path
// Scale the delayed sample by 3/5 (truncated toward zero), add the input,
// and hold the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sted_echo_path (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic signed [sted_pkg::SAMP_W-1:0]  i_sample,
    input  wire sted_pkg::t_tag                      i_tag,
    input  wire logic        [sted_pkg::SAMP_W-1:0]  i_rd_data,
    input  wire logic                                i_out_stall,
    output logic                                     o_busy,
    output logic                                     o_out_valid,
    output logic signed      [sted_pkg::SAMP_W-1:0]  o_sample_out
);

    // Stage B: memory data arrives
    logic                                r_b_vld;
    logic signed [sted_pkg::SAMP_W-1:0]  r_b_x;
    sted_pkg::t_tag                      r_b_tag;
    // Stage C: tripled magnitude
    logic                                r_c_vld;
    logic signed [sted_pkg::SAMP_W-1:0]  r_c_x;
    logic                                r_c_neg;
    logic [sted_pkg::TRIPLE_W-1:0]       r_c_n;
    // Output register
    logic                                r_o_vld;
    logic signed [sted_pkg::SAMP_W-1:0]  r_o_y;

    logic                                b_adv;
    logic                                c_adv;
    logic [sted_pkg::SAMP_W-1:0]         past;
    logic [sted_pkg::TRIPLE_W-1:0]       mag;
    logic [sted_pkg::TRIPLE_W-1:0]       n_triple;
    logic [sted_pkg::PROD_W-1:0]         prod;
    logic [sted_pkg::SAMP_W-1:0]         quot;
    logic [sted_pkg::SAMP_W-1:0]         term;
    logic signed [sted_pkg::SAMP_W-1:0]  n_y;

    // Stage handshake: a stage moves when the next one is free or moving
    assign c_adv  = !r_o_vld || !i_out_stall;
    assign b_adv  = !r_c_vld || c_adv;
    assign o_busy = r_b_vld && !b_adv;

    // Select the delayed sample and form 3*|past|; no echo gives zero
    always_comb begin
        past = r_b_tag.zero ? r_b_x : i_rd_data;
        mag  = {{(sted_pkg::TRIPLE_W - sted_pkg::SAMP_W){past[sted_pkg::SAMP_W-1]}}, past};
        if (past[sted_pkg::SAMP_W-1]) begin
            mag = ~mag + 1'b1;
        end
        n_triple = r_b_tag.echo ? mag + (mag << 1) : '0;
    end

    // Divide by five through the reciprocal, restore sign, add the input
    always_comb begin
        prod = sted_pkg::PROD_W'(r_c_n) * sted_pkg::PROD_W'(sted_pkg::DIV5_MUL);
        quot = sted_pkg::SAMP_W'(prod >> sted_pkg::DIV5_SHIFT);
        term = r_c_neg ? -quot : quot;
        n_y  = r_c_x + $signed(term);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (!o_busy) begin
                r_b_vld <= i_accept;
            end
            if (b_adv) begin
                r_c_vld <= r_b_vld;
            end
            if (c_adv) begin
                r_o_vld <= r_c_vld;
            end
        end
    end

    // Payload registers: hold while the stage is blocked
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_x   <= i_sample;
            r_b_tag <= i_tag;
        end
        if (b_adv && r_b_vld) begin
            r_c_x   <= r_b_x;
            r_c_neg <= past[sted_pkg::SAMP_W-1];
            r_c_n   <= n_triple;
        end
        if (c_adv && r_c_vld) begin
            r_o_y <= n_y;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_sample_out = r_o_y;

endmodule

`default_nettype wire

FILE: design/single_tap_echo_delay_unit.sv
// ----------------------------------------------------------------------------
// single_tap_echo_delay_unit
// Feedforward comb filter: out = in + trunc(3/5 * in delayed by N samples),
// with the echo term enabled once N samples of the current clip are seen.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+----------------------------------
//   input    | i_in_valid / o_in_stall     | i_sample_in, i_clip_start
//   output   | o_out_valid / i_out_stall   | o_sample_out
//   config   | i_cfg_valid / o_cfg_ready   | i_cfg_delay_samples
//
// One sample per cycle sustained while the output is not stalled; an input
// transaction reaches the output register through the delay memory read
// plus two arithmetic stages (triple, then reciprocal multiply and add).
// Reset is synchronous; the delay memory is not cleared and needs no pass.
// Output stall holds the result register; the input stalls only once every
// pipeline stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module single_tap_echo_delay_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [sted_pkg::SAMP_W-1:0]  i_sample_in,
    input  wire logic                                i_clip_start,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed      [sted_pkg::SAMP_W-1:0]  o_sample_out,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic        [sted_pkg::DLY_W-1:0]   i_cfg_delay_samples
);

    logic                          r_delay;
    logic [sted_pkg::DLY_W-1:0]    r_delay_samples;
    logic                          busy;
    logic                          accept;
    logic [sted_pkg::ADDR_W-1:0]   wr_addr;
    logic [sted_pkg::ADDR_W-1:0]   rd_addr;
    logic [sted_pkg::SAMP_W-1:0]   rd_data;
    sted_pkg::t_tag                tag;

    assign o_cfg_ready = r_delay;
    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;

    // Delay register; ready comes up once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay         <= 1'b0;
            r_delay_samples <= '0;
        end else begin
            r_delay <= 1'b1;
            if (i_cfg_valid && r_delay) begin
                r_delay_samples <= i_cfg_delay_samples;
            end
        end
    end

    sted_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_clip_start (i_clip_start),
        .i_delay      (r_delay_samples),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_tag        (tag)
    );

    sted_delay_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample_in),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sted_echo_path u_path (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sample     (i_sample_in),
        .i_tag        (tag),
        .i_rd_data    (rd_data),
        .i_out_stall  (i_out_stall),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

`default_nettype wire

FILE: design/sted_checker.sv
// ----------------------------------------------------------------------------
// sted_checker
// Port-level checks on the echo delay unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sted_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [sted_pkg::SAMP_W-1:0]   o_sample_out
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output transaction changed");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Input never stalls while the output register is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // A transaction reaches the output when the output stays unstalled behind it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall
        |=> o_out_valid)
        else $error("output transaction late");

endmodule

bind single_tap_echo_delay_unit sted_checker u_sted_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out)
);

`default_nettype wire

FILE: tb/sted_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sted_tb_pkg
// Scoreboard for the single-tap echo delay unit: it tracks the echo history,
// predicts each output sample and compares it against the block's output.
// ----------------------------------------------------------------------------

package sted_tb_pkg;

    class echo_scoreboard;

        logic        [sted_pkg::DLY_W-1:0]  delay_reg;
        logic signed [sted_pkg::SAMP_W-1:0] past_samples [sted_pkg::DELAY_DEPTH];
        int                                 write_ptr;
        logic        [15:0]                 clip_count;
        logic signed [sted_pkg::SAMP_W-1:0] pending_outputs [$];
        int                                 mismatches;

        function new();
            delay_reg  = '0;
            write_ptr  = 0;
            clip_count = '0;
            mismatches = 0;
        endfunction

        function void set_delay(logic [sted_pkg::DLY_W-1:0] value);
            delay_reg = value;
        endfunction

        // Predict the output for one input transaction and queue it
        function void take_sample(logic signed [sted_pkg::SAMP_W-1:0] x, logic start);
            int eff;
            int past;
            int sum;
            int rd;
            // Clamp the delay to the history depth
            eff = (delay_reg > sted_pkg::DELAY_DEPTH) ? sted_pkg::DELAY_DEPTH
                                                      : int'(delay_reg);
            if (start) begin
                clip_count = '0;
            end
            sum = x;
            // Add the scaled echo once enough samples of this clip went by
            if (int'(clip_count) >= eff) begin
                if (eff == 0) begin
                    past = x;
                end else begin
                    rd   = (write_ptr + sted_pkg::DELAY_DEPTH - eff) % sted_pkg::DELAY_DEPTH;
                    past = past_samples[rd];
                end
                sum = x + (3 * past) / 5;
            end
            past_samples[write_ptr] = x;
            write_ptr = (write_ptr + 1) % sted_pkg::DELAY_DEPTH;
            if (clip_count != 16'hFFFF) begin
                clip_count++;
            end
            pending_outputs.push_back(16'(sum));
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_output(logic signed [sted_pkg::SAMP_W-1:0] actual);
            logic signed [sted_pkg::SAMP_W-1:0] want;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $error("sample_out: no prediction waiting, expected none, actual %0d",
                       actual);
                return;
            end
            want = pending_outputs.pop_front();
            if (actual !== want) begin
                mismatches++;
                $error("sample_out: expected %0d, actual %0d", want, actual);
            end
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_single_tap_echo_delay_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_tap_echo_delay_unit
// Drives PCM samples through the echo delay unit under random input gaps and
// output stalls, across several delay settings including zero, the history
// depth and the register maximum, and checks every output sample in order.
// ----------------------------------------------------------------------------

module tb_single_tap_echo_delay_unit;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                               i_clk;
    logic                               i_rst_n             = 1'b0;
    logic                               i_in_valid          = 1'b0;
    logic                               o_in_stall;
    logic signed [sted_pkg::SAMP_W-1:0] i_sample_in         = '0;
    logic                               i_clip_start        = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_stall         = 1'b0;
    logic signed [sted_pkg::SAMP_W-1:0] o_sample_out;
    logic                               i_cfg_valid         = 1'b0;
    logic                               o_cfg_ready;
    logic        [sted_pkg::DLY_W-1:0]  i_cfg_delay_samples = '0;

    sted_tb_pkg::echo_scoreboard board;
    int             burst_left = 0;
    bit             gapless    = 1'b0;
    t_stall_mode    stall_mode = STALL_NONE;
    int             stall_left = 0;
    int             cycle_ctr  = 0;

    single_tap_echo_delay_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample_in         (i_sample_in),
        .i_clip_start        (i_clip_start),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_sample_out        (o_sample_out),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_delay_samples (i_cfg_delay_samples)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check output transactions and drive the output stall pattern
    always @(posedge i_clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_output(o_sample_out);
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_out_stall <= ((cycle_ctr % 5) < 2);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // Present one sample and hold it until the block takes it
    task automatic send_sample(input logic signed [sted_pkg::SAMP_W-1:0] s, input logic st);
        i_in_valid   <= 1'b1;
        i_sample_in  <= s;
        i_clip_start <= st;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        board.take_sample(s, st);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Send in bursts of random length with random gaps in between, unless gapless
    task automatic send_paced(input logic signed [sted_pkg::SAMP_W-1:0] s, input logic st);
        if (burst_left == 0) begin
            if (!gapless) begin
                idle_input($urandom_range(0, 6));
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_sample(s, st);
    endtask

    // Hold off input until every predicted output has come back
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the delay register while the block is idle
    task automatic write_delay(input logic [sted_pkg::DLY_W-1:0] value);
        drain_outputs();
        i_cfg_valid         <= 1'b1;
        i_cfg_delay_samples <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        board.set_delay(value);
    endtask

    function automatic logic signed [sted_pkg::SAMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 31)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    // Run clips sized past the delay, with stray restarts as noise
    task automatic run_random_phase(input logic [sted_pkg::DLY_W-1:0] dly, input int count,
                                    input bit keep_clip, input bit pause_mid);
        int   clip_left;
        int   eff;
        logic st;
        eff       = (dly > sted_pkg::DELAY_DEPTH) ? sted_pkg::DELAY_DEPTH : int'(dly);
        clip_left = keep_clip ? $urandom_range(1, 60) : 0;
        gapless   = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            if (clip_left == 0) begin
                st        = 1'b1;
                clip_left = eff + $urandom_range(1, 60);
            end else begin
                st = ($urandom_range(0, 24) == 0);
            end
            clip_left--;
            if (pause_mid && n == count / 2) begin
                drain_outputs();
            end
            send_paced(pick_sample(), st);
        end
    endtask

    // Give up on a hung run
    initial begin
        #(8_000_000);
        $display("[single_tap_echo_delay_unit] ERROR");
        $finish;
    end

    initial begin
        logic [sted_pkg::DLY_W-1:0] phase_delays [10];
        int                         count;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero delay from reset: each sample echoes itself
        send_paced(16'sh7FFF, 1'b1);
        send_paced(16'sh8000, 1'b0);
        send_paced(16'sh0000, 1'b0);
        send_paced(-16'sd1, 1'b0);
        send_paced(16'sd1, 1'b0);
        send_paced(16'sd5, 1'b0);
        send_paced(-16'sd5, 1'b0);

        // One-sample delay: full-scale swings wrap both ways
        write_delay(16'd1);
        send_paced(16'sh8000, 1'b1);
        send_paced(16'sh7FFF, 1'b0);
        send_paced(16'sh7FFF, 1'b0);
        send_paced(16'sh8000, 1'b0);
        send_paced(16'sh8000, 1'b0);
        send_paced(16'sd7, 1'b1);
        send_paced(16'sd3, 1'b0);

        // Short delay with a clip restart before the echo settles
        write_delay(16'd2);
        send_paced(16'sd100, 1'b1);
        send_paced(16'sd200, 1'b0);
        send_paced(16'sd300, 1'b0);
        send_paced(16'sd400, 1'b1);
        send_paced(16'sd500, 1'b0);
        send_paced(16'sd600, 1'b0);

        // Register maximum: clamped to the history depth, echo stays off
        write_delay(16'hFFFF);
        send_paced(16'sd1234, 1'b1);
        send_paced(-16'sd1234, 1'b0);

        // Random phases over a spread of delays
        phase_delays = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd13, 16'd64, 16'd150,
                         16'($urandom_range(3, 30)), 16'($urandom_range(60, 120)),
                         16'd1};
        for (int p = 0; p < 10; p++) begin
            write_delay(phase_delays[p]);
            count = (int'(phase_delays[p]) + 40 > 55) ? int'(phase_delays[p]) + 40 : 55;
            run_random_phase(phase_delays[p], count, (p % 2) == 1, (p % 3) == 0);
        end

        // Full-depth delay: a short clip keeps the echo off
        write_delay(16'(sted_pkg::DELAY_DEPTH));
        gapless = 1'b0;
        send_paced(pick_sample(), 1'b1);
        for (int n = 0; n < 39; n++) begin
            send_paced(pick_sample(), 1'b0);
        end

        // Change the delay within the running clip
        write_delay(16'hFFFF);
        for (int n = 0; n < 20; n++) begin
            send_paced(pick_sample(), 1'b0);
        end
        write_delay(16'd8);
        for (int n = 0; n < 40; n++) begin
            send_paced(pick_sample(), 1'b0);
        end
        send_paced(pick_sample(), 1'b1);
        for (int n = 0; n < 16; n++) begin
            send_paced(pick_sample(), 1'b0);
        end

        // Let the pipeline empty, then report
        drain_outputs();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("[single_tap_echo_delay_unit] OK");
        end else begin
            $display("[single_tap_echo_delay_unit] ERROR");
        end
        $finish;
    end

endmodule
